FILE: rtl/modbus_rtu_response_checker_macros.svh
// ----------------------------------------------------------------------------
// Modbus RTU response checker: assertion macros
// Shared property shorthands for the checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBRC_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBRC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Item types, status codes, frame constants and the CRC-16/Modbus byte step.
// ----------------------------------------------------------------------------
package mbrc_pkg;

    localparam int MAX_REGS_DEFAULT  = 16;
    localparam int FRAME_MAX_DEFAULT = 256;

    localparam int          MIN_FRAME  = 5;
    localparam int          DATA_START = 3;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam int FUNC_W  = 7;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 7;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_FUNCTION = 1'b0;
    localparam logic CFG_REGISTER_COUNT    = 1'b1;

    // Result item kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_CRC_ERROR  = 3'd2,
        ST_EXCEPTION  = 3'd3,
        ST_MISMATCH   = 3'd4,
        ST_DATA_SHORT = 3'd5
    } status_t;

    typedef enum logic {
        PH_IDLE,
        PH_WORDS
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } rx_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic [15:0] register_word;
        logic        run_last;
    } result_item_t;

    // One byte through the reflected CRC-16/Modbus shift register.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/mbrc_word_mem.sv
// ----------------------------------------------------------------------------
// Register word store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mbrc_word_mem #(
    parameter int DEPTH = mbrc_pkg::MAX_REGS_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Checks one response frame byte by byte and returns status and register words.
// ----------------------------------------------------------------------------
// Usage: each response byte is presented on rx with start; it is taken at a
// clock edge where start is high and busy is low. The end_of_frame flag marks
// the last byte of a frame. Bytes are taken one per cycle while a frame is
// being received, and the CRC is updated in the same cycle.
// In the cycle after the last byte is taken, the status item appears on
// result with strobe high for one cycle. If the status is ok and the expected
// count n (capped at MAX_REGS) is nonzero, n register word items follow, one
// per cycle, read from the word memory through its single read port; busy is
// high from the status item cycle through the cycle of the next to last word
// item. run_last marks the final item of each frame.
// The receiver cannot stall: every item is valid for exactly one cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Reset clears the frame state and sets the registers to their defaults; the
// word memory needs no clearing, since only words written in the current
// frame are ever read out.
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_checker_macros.svh"

module modbus_rtu_response_checker #(
    parameter int MAX_REGS  = mbrc_pkg::MAX_REGS_DEFAULT,
    parameter int FRAME_MAX = mbrc_pkg::FRAME_MAX_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  mbrc_pkg::rx_item_t     rx,
    output logic                   strobe,
    output mbrc_pkg::result_item_t result,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [mbrc_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int NW    = $clog2(MAX_REGS + 1);
    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int LW    = ((AW > NW) ? AW : NW) + 1;

    // Configuration registers.
    logic [mbrc_pkg::FUNC_W-1:0]  exp_func_reg;
    logic [mbrc_pkg::COUNT_W-1:0] reg_count_reg;

    // Frame state.
    logic [15:0]      crc_reg,   crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       func_reg,  func_next;
    logic [7:0]       exc_reg,   exc_next;
    logic [7:0]       hold_reg,  hold_next;

    // Output and word run control.
    mbrc_pkg::phase_t  ph_reg, ph_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic              strobe_reg, strobe_next;
    logic              kind_reg, kind_next;
    mbrc_pkg::status_t status_reg, status_next;
    logic [7:0]        excout_reg, excout_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              take_byte;
    logic [CNT_W-1:0]  rel;
    logic [CNT_W-2:0]  word_pos;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [15:0]       mem_rdata;
    logic [NW-1:0]     n_eff;
    logic              word_last;
    mbrc_pkg::status_t st;

    assign accept    = start && !busy;
    assign busy      = (ph_reg != mbrc_pkg::PH_IDLE);
    assign take_byte = (int'(count_reg) < FRAME_MAX);
    assign rel       = count_reg - CNT_W'(mbrc_pkg::DATA_START);
    assign word_pos  = rel[CNT_W-1:1];
    assign mem_waddr = AW'(word_pos);

    // Counts above the store depth saturate.
    assign n_eff = (int'(reg_count_reg) > MAX_REGS) ? NW'(MAX_REGS) : NW'(reg_count_reg);
    assign word_last = (LW'(rd_idx_reg) + LW'(1)) == LW'(n_eff);

    // Byte intake: CRC, header bytes and word assembly.
    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        func_next  = func_reg;
        exc_next   = exc_reg;
        hold_next  = hold_reg;
        mem_we     = 1'b0;
        if (accept && take_byte)
        begin
            crc_next   = mbrc_pkg::crc16_feed(crc_reg, rx.rx_byte);
            count_next = count_reg + CNT_W'(1);
            if (int'(count_reg) == 1)
            begin
                func_next = rx.rx_byte;
            end
            else if (int'(count_reg) == 2)
            begin
                exc_next = rx.rx_byte;
            end
            else if (int'(count_reg) >= mbrc_pkg::DATA_START)
            begin
                if (!rel[0])
                begin
                    hold_next = rx.rx_byte;
                end
                else if (int'(word_pos) < MAX_REGS)
                begin
                    mem_we = 1'b1;
                end
            end
        end
    end

    // Frame verdict, evaluated on the updated state of the final byte.
    always_comb
    begin
        priority if (int'(count_next) < mbrc_pkg::MIN_FRAME)
            st = mbrc_pkg::ST_TOO_SHORT;
        else if (crc_next != 16'h0000)
            st = mbrc_pkg::ST_CRC_ERROR;
        else if (func_next == ({1'b0, exp_func_reg} | mbrc_pkg::EXC_FLAG))
            st = mbrc_pkg::ST_EXCEPTION;
        else if (func_next != {1'b0, exp_func_reg})
            st = mbrc_pkg::ST_MISMATCH;
        else if (CMP_W'(count_next) <
                 (CMP_W'(mbrc_pkg::MIN_FRAME) + (CMP_W'(n_eff) << 1)))
            st = mbrc_pkg::ST_DATA_SHORT;
        else
            st = mbrc_pkg::ST_OK;
    end

    // Result sequencing.
    always_comb
    begin
        ph_next     = ph_reg;
        rd_idx_next = rd_idx_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        status_next = status_reg;
        excout_next = excout_reg;
        last_next   = last_reg;
        unique case (ph_reg)
            mbrc_pkg::PH_IDLE:
            begin
                if (accept && rx.end_of_frame)
                begin
                    strobe_next = 1'b1;
                    kind_next   = mbrc_pkg::KIND_STATUS;
                    status_next = st;
                    excout_next = (st == mbrc_pkg::ST_EXCEPTION) ? exc_next : 8'h00;
                    last_next   = (st != mbrc_pkg::ST_OK) || (n_eff == '0);
                    rd_idx_next = '0;
                    if ((st == mbrc_pkg::ST_OK) && (n_eff != '0))
                    begin
                        ph_next = mbrc_pkg::PH_WORDS;
                    end
                end
            end
            mbrc_pkg::PH_WORDS:
            begin
                strobe_next = 1'b1;
                kind_next   = mbrc_pkg::KIND_WORD;
                status_next = mbrc_pkg::ST_OK;
                excout_next = 8'h00;
                last_next   = word_last;
                rd_idx_next = rd_idx_reg + AW'(1);
                if (word_last)
                begin
                    ph_next = mbrc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                ph_next = mbrc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_func_reg  <= mbrc_pkg::FUNC_W'(3);
            reg_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrc_pkg::CFG_EXPECTED_FUNCTION: exp_func_reg  <= cfg_data;
                mbrc_pkg::CFG_REGISTER_COUNT:
                    reg_count_reg <= cfg_data[mbrc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The frame state returns to its reset values after every final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mbrc_pkg::CRC_INIT;
            count_reg <= '0;
            func_reg  <= '0;
            exc_reg   <= '0;
            hold_reg  <= '0;
        end
        else if (accept && rx.end_of_frame)
        begin
            crc_reg   <= mbrc_pkg::CRC_INIT;
            count_reg <= '0;
            func_reg  <= '0;
            exc_reg   <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            func_reg  <= func_next;
            exc_reg   <= exc_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= mbrc_pkg::PH_IDLE;
            rd_idx_reg <= '0;
            strobe_reg <= 1'b0;
            kind_reg   <= mbrc_pkg::KIND_STATUS;
            status_reg <= mbrc_pkg::ST_OK;
            excout_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            ph_reg     <= ph_next;
            rd_idx_reg <= rd_idx_next;
            strobe_reg <= strobe_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            excout_reg <= excout_next;
            last_reg   <= last_next;
        end
    end

    mbrc_word_mem #(
        .DEPTH (MAX_REGS),
        .AW    (AW)
    ) u_word_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({hold_reg, rx.rx_byte}),
        .re    (ph_reg == mbrc_pkg::PH_WORDS),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    assign strobe                = strobe_reg;
    assign result.item_kind      = kind_reg;
    assign result.status         = status_reg;
    assign result.exception_code = excout_reg;
    assign result.register_word  = (kind_reg == mbrc_pkg::KIND_WORD) ? mem_rdata : 16'h0000;
    assign result.run_last       = last_reg;

    `MBRC_ASSERT_NEXT(a_eof_gives_status, clk, rst_n, accept && rx.end_of_frame, strobe && (result.item_kind == mbrc_pkg::KIND_STATUS), "final byte did not produce a status item")
    `MBRC_ASSERT_NEXT(a_run_gives_word, clk, rst_n, ph_reg == mbrc_pkg::PH_WORDS, strobe && (result.item_kind == mbrc_pkg::KIND_WORD), "word run cycle did not produce a word item")
    `MBRC_ASSERT_SAME(a_last_ends_run, clk, rst_n, strobe && result.run_last, ph_reg == mbrc_pkg::PH_IDLE, "final item seen while the word run continues")
    `MBRC_ASSERT_SAME(a_error_is_last, clk, rst_n, strobe && (result.status != mbrc_pkg::ST_OK), result.run_last, "error status was not the final item of its frame")

endmodule

FILE: verif/modbus_rtu_response_checker_tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Feeds response frames byte by byte under several register settings and
// idle patterns, predicts the status and register word items of each frame,
// and compares every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module modbus_rtu_response_checker_tb;
    import mbrc_pkg::*;

    localparam int MAX_REGS       = 16;
    localparam int FRAME_MAX      = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_BYTES    = 10;
    localparam int NUM_PHASES     = 7;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    rx_item_t         rx        = '0;
    logic             strobe;
    result_item_t     result;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_EXPECTED_FUNCTION;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Predictor state: one frame in progress plus the two registers.
    logic [15:0]        frame_crc;
    logic [8:0]         frame_len;
    logic [7:0]         fn_byte;
    logic [7:0]         exc_byte;
    logic [7:0]         hi_byte;
    logic [15:0]        word_mem [MAX_REGS];
    logic [FUNC_W-1:0]  want_func  = 7'd3;
    logic [COUNT_W-1:0] want_count = 5'd0;

    rx_item_t     tx_bytes[$];
    result_item_t predicted_replies[$];
    logic [7:0]   frame_buf[$];

    int unsigned queued_bytes = 0;
    int unsigned gap_pct      = 0;
    int unsigned errors       = 0;
    int unsigned idle_cycles  = 0;

    modbus_rtu_response_checker #(
        .MAX_REGS  (MAX_REGS),
        .FRAME_MAX (FRAME_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .rx        (rx),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Bit-serial form of the reflected CRC-16/Modbus register.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    task automatic clear_frame_state();
        frame_crc = CRC_INIT;
        frame_len = '0;
        fn_byte   = '0;
        exc_byte  = '0;
        hi_byte   = '0;
    endtask

    // Absorbs one accepted byte and, on the final byte, queues the replies.
    task automatic track_frame_byte(input rx_item_t it);
        int unsigned  idx;
        int unsigned  n;
        status_t      st;
        result_item_t r;
        if (frame_len < FRAME_MAX)
        begin
            idx       = frame_len;
            frame_crc = crc_step(frame_crc, it.rx_byte);
            if (idx == 1)
                fn_byte = it.rx_byte;
            else if (idx == 2)
                exc_byte = it.rx_byte;
            else if (idx >= DATA_START)
            begin
                if (((idx - DATA_START) & 1) == 0)
                    hi_byte = it.rx_byte;
                else if (((idx - DATA_START) >> 1) < MAX_REGS)
                    word_mem[(idx - DATA_START) >> 1] = {hi_byte, it.rx_byte};
            end
            frame_len = frame_len + 9'd1;
        end
        if (it.end_of_frame)
        begin
            n = (want_count > MAX_REGS) ? MAX_REGS : want_count;
            if (frame_len < MIN_FRAME)
                st = ST_TOO_SHORT;
            else if (frame_crc != 16'h0000)
                st = ST_CRC_ERROR;
            else if (fn_byte == ({1'b0, want_func} | EXC_FLAG))
                st = ST_EXCEPTION;
            else if (fn_byte != {1'b0, want_func})
                st = ST_MISMATCH;
            else if (frame_len < MIN_FRAME + 2 * n)
                st = ST_DATA_SHORT;
            else
                st = ST_OK;
            r                = '0;
            r.item_kind      = KIND_STATUS;
            r.status         = st;
            r.exception_code = (st == ST_EXCEPTION) ? exc_byte : 8'h00;
            r.run_last       = (st != ST_OK) || (n == 0);
            predicted_replies.push_back(r);
            if (st == ST_OK)
            begin
                for (int i = 0; i < n; i++)
                begin
                    r               = '0;
                    r.item_kind     = KIND_WORD;
                    r.register_word = word_mem[i];
                    r.run_last      = (i + 1 == n);
                    predicted_replies.push_back(r);
                end
            end
            clear_frame_state();
        end
    endtask

    task automatic start_frame(input logic [7:0] addr, input logic [7:0] fn,
                               input logic [7:0] third);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fn);
        frame_buf.push_back(third);
    endtask

    task automatic push_random_bytes(input int unsigned count);
        for (int i = 0; i < count; i++)
            frame_buf.push_back(8'($urandom));
    endtask

    // Appends the CRC low byte first, as on the wire.
    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i])
            c = crc_step(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic send_frame();
        rx_item_t it;
        foreach (frame_buf[i])
        begin
            it.rx_byte      = frame_buf[i];
            it.end_of_frame = (i == frame_buf.size() - 1);
            tx_bytes.push_back(it);
        end
        queued_bytes += frame_buf.size();
    endtask

    // Mostly well-formed replies with random content, the rest broken or noise.
    task automatic random_frame();
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        logic [7:0]  fn;
        logic [7:0]  good_fn;
        n       = (want_count > MAX_REGS) ? MAX_REGS : want_count;
        good_fn = {1'b0, want_func};
        kind    = $urandom_range(99);
        if (kind < 55)
        begin
            start_frame(8'($urandom), good_fn, 8'(2 * n));
            push_random_bytes(2 * n + $urandom_range(3));
            append_crc();
        end
        else if (kind < 65)
        begin
            start_frame(8'($urandom), good_fn | EXC_FLAG, 8'($urandom));
            push_random_bytes($urandom_range(2));
            append_crc();
        end
        else if (kind < 73)
        begin
            fn = 8'($urandom);
            while (fn == good_fn || fn == (good_fn | EXC_FLAG))
                fn = 8'($urandom);
            start_frame(8'($urandom), fn, 8'($urandom));
            push_random_bytes($urandom_range(2 * n + 2));
            append_crc();
        end
        else if (kind < 81)
        begin
            // A single flipped bit anywhere, CRC bytes included.
            start_frame(8'($urandom), good_fn, 8'(2 * n));
            push_random_bytes(2 * n + $urandom_range(3));
            append_crc();
            pos = $urandom_range(frame_buf.size() - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'(1 << $urandom_range(7));
        end
        else if (kind < 89)
        begin
            start_frame(8'($urandom), good_fn, 8'(2 * n));
            if (n > 0)
                push_random_bytes($urandom_range(2 * n - 1));
            append_crc();
        end
        else if (kind < 95)
        begin
            frame_buf.delete();
            push_random_bytes($urandom_range(1, 4));
        end
        else
        begin
            frame_buf.delete();
            push_random_bytes($urandom_range(1, 40));
        end
        send_frame();
    endtask

    // Valid reply filling the frame limit, then bytes the block must ignore.
    task automatic overlong_frame();
        int unsigned n;
        n = (want_count > MAX_REGS) ? MAX_REGS : want_count;
        start_frame(8'($urandom), {1'b0, want_func}, 8'(2 * n));
        push_random_bytes(FRAME_MAX - 2 - frame_buf.size());
        append_crc();
        push_random_bytes($urandom_range(1, 6));
        send_frame();
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EXPECTED_FUNCTION)
            want_func = val[FUNC_W-1:0];
        else
            want_count = val[COUNT_W-1:0];
    endtask

    task automatic wait_idle();
        while (tx_bytes.size() != 0 || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: the front item stays on the bus until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            rx    <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                track_frame_byte(rx);
                tx_bytes.delete(0);
            end
            if (!(start && busy))
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start <= 1'b1;
                    rx    <= tx_bytes[0];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed item is taken and checked.
    always @(posedge clk)
    begin : result_monitor
        result_item_t want;
        if (rst_n && strobe)
        begin
            if (predicted_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result item kind %0d status %0d exc %h word %h last %0d",
                             $time, result.item_kind, result.status,
                             result.exception_code, result.register_word, result.run_last);
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (result.item_kind !== want.item_kind || result.status !== want.status ||
                    result.exception_code !== want.exception_code ||
                    result.register_word !== want.register_word ||
                    result.run_last !== want.run_last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: mismatch: got kind %0d status %0d exc %h word %h last %0d, expected kind %0d status %0d exc %h word %h last %0d",
                                 $time, result.item_kind, result.status,
                                 result.exception_code, result.register_word, result.run_last,
                                 want.item_kind, want.status, want.exception_code,
                                 want.register_word, want.run_last);
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] phase_func [NUM_PHASES];
        logic [CFG_W-1:0] phase_count [NUM_PHASES];
        int unsigned      phase_gap [NUM_PHASES];
        int unsigned      mark;

        phase_func  = '{7'd3, 7'd127, 7'd1, 7'd0, 7'($urandom_range(1, 127)), 7'd3, 7'd127};
        // A count above the store size saturates; the full-width write also
        // exercises the data bits above the register.
        phase_count = '{7'd2, 7'd16, 7'h7F, 7'd1, 7'($urandom_range(16)), 7'd0, 7'd5};
        phase_gap   = '{73, 0, 15, 73, 0, 15, 73};

        clear_frame_state();
        foreach (word_mem[i])
            word_mem[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: function 3, no register words.
        gap_pct = 0;
        start_frame(8'h00, 8'h03, 8'h00);
        append_crc();
        send_frame();
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        start_frame(8'h01, 8'h83, 8'hFF);
        append_crc();
        send_frame();
        start_frame(8'h01, 8'h04, 8'h00);
        append_crc();
        send_frame();
        start_frame(8'hF7, 8'h03, 8'h00);
        append_crc();
        frame_buf[4] = frame_buf[4] ^ 8'h01;
        send_frame();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_EXPECTED_FUNCTION, phase_func[p]);
            write_reg(CFG_REGISTER_COUNT, phase_count[p]);
            gap_pct = phase_gap[p];
            // The overlong frame fills the byte budget of its phase.
            mark = queued_bytes;
            if (p == 1)
                overlong_frame();
            while (queued_bytes - mark < PHASE_BYTES)
                random_frame();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && predicted_replies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: modbus_rtu_response_checker.f
+incdir+rtl
rtl/mbrc_pkg.sv
rtl/mbrc_word_mem.sv
rtl/modbus_rtu_response_checker.sv
verif/modbus_rtu_response_checker_tb.sv
